>>> src/ctlex_pkg.sv
// Types, token codes and keyword tables shared by the lexer core and its step logic.
`default_nettype none
package ctlex_pkg;

    typedef enum logic [3:0] {
        KIND_END     = 4'd0,
        KIND_LPAR    = 4'd1,
        KIND_RPAR    = 4'd2,
        KIND_LBRACE  = 4'd3,
        KIND_RBRACE  = 4'd4,
        KIND_SEMI    = 4'd5,
        KIND_INT     = 4'd6,
        KIND_CHAR    = 4'd7,
        KIND_VOID    = 4'd8,
        KIND_RETURN  = 4'd9,
        KIND_IDENT   = 4'd10,
        KIND_NUMBER  = 4'd11,
        KIND_UNKNOWN = 4'd12,
        KIND_ECHO    = 4'd13
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2
    } mode_t;

    localparam int unsigned KW_COUNT   = 4;
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Scanner state carried from one byte to the next
    typedef struct packed {
        mode_t       mode;
        logic [3:0]  cand;
        logic [5:0]  wlen;
        logic [31:0] acc;
        logic [15:0] line;
    } lex_state_t;

    // Results raised by one byte, oldest in kind0
    typedef struct packed {
        logic [1:0] count;
        kind_t      kind0;
        kind_t      kind1;
    } lex_res_t;

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        case (k)
            2'd0:    kw_len = 3'd3;
            2'd1:    kw_len = 3'd4;
            2'd2:    kw_len = 3'd4;
            default: kw_len = 3'd6;
        endcase
    endfunction

    function automatic kind_t kw_kind(input logic [1:0] k);
        case (k)
            2'd0:    kw_kind = KIND_INT;
            2'd1:    kw_kind = KIND_CHAR;
            2'd2:    kw_kind = KIND_VOID;
            default: kw_kind = KIND_RETURN;
        endcase
    endfunction

    // Character of keyword k at position pos (pos below its length)
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        case ({k, pos})
            {2'd0, 3'd0}: kw_char = "i";
            {2'd0, 3'd1}: kw_char = "n";
            {2'd0, 3'd2}: kw_char = "t";
            {2'd1, 3'd0}: kw_char = "c";
            {2'd1, 3'd1}: kw_char = "h";
            {2'd1, 3'd2}: kw_char = "a";
            {2'd1, 3'd3}: kw_char = "r";
            {2'd2, 3'd0}: kw_char = "v";
            {2'd2, 3'd1}: kw_char = "o";
            {2'd2, 3'd2}: kw_char = "i";
            {2'd2, 3'd3}: kw_char = "d";
            {2'd3, 3'd0}: kw_char = "r";
            {2'd3, 3'd1}: kw_char = "e";
            {2'd3, 3'd2}: kw_char = "t";
            {2'd3, 3'd3}: kw_char = "u";
            {2'd3, 3'd4}: kw_char = "r";
            {2'd3, 3'd5}: kw_char = "n";
            default:      kw_char = 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> src/c_subset_token_lexer_core.sv
// Top level of the byte-serial lexer for a small C subset.
//
//  channel | direction | handshake              | content
//  --------+-----------+------------------------+------------------------------
//  s_      | in        | s_tvalid / s_tready    | one source byte per word
//  m_      | out       | m_tvalid / m_tready    | one token kind per word
//  cfg_    | in        | cfg_valid / cfg_ready  | start_line register write
//
// One source byte is taken per cycle; each byte is lexed in the cycle it is
// accepted and its zero, one or two token words are pushed into a four-entry
// output queue, which drains one word per cycle from the next cycle on.
// s_tready is high while at least two queue entries are free, so input stalls
// when the sink holds m_tready low, or when a byte raising two
// words follows an earlier one with no silent byte between them.
// Synchronous active-low reset empties the queue, returns the scanner to idle
// and loads start_line with 1. cfg_ready is always high.
`default_nettype none
module c_subset_token_lexer_core #(
    parameter int unsigned LINE_BITS       = 16,
    parameter int unsigned MAX_WORD_LENGTH = 63
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // source_byte [7:0]
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // token_kind [3:0], zero above
    output logic [7:0]       m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);
    import ctlex_pkg::*;

    // Line counter saturates at the smaller of 2^LINE_BITS-1 and the 16-bit limit
    localparam logic [31:0] LIMIT_WIDE = (LINE_BITS >= 16) ? 32'h0000_FFFF :
                                         (32'd1 << LINE_BITS) - 32'd1;
    localparam logic [15:0] LINE_LIMIT = LIMIT_WIDE[15:0];
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    lex_state_t        st_reg, st_next;
    lex_state_t        step_nxt;
    lex_res_t          step_res;
    logic [15:0]       start_reg, start_next;
    logic [15:0]       start_clamp, cfg_clamp;

    kind_t             q_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              s_fire, m_fire;
    logic [1:0]        push_n;

    assign cfg_ready   = 1'b1;
    assign start_clamp = (start_reg > LINE_LIMIT) ? LINE_LIMIT : start_reg;
    assign cfg_clamp   = (cfg_data > LINE_LIMIT) ? LINE_LIMIT : cfg_data;

    assign s_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = {4'd0, q_mem[head_reg]};

    ctlex_step #(
        .LINE_LIMIT      (LINE_LIMIT),
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    ) u_step (
        .src_byte    (s_tdata),
        .cur         (st_reg),
        .line_reload (start_clamp),
        .nxt         (step_nxt),
        .res         (step_res)
    );

    // Advance scanner state on an accepted byte; a register write reloads the line
    always_comb begin
        st_next    = s_fire ? step_nxt : st_reg;
        start_next = start_reg;
        if (cfg_valid && cfg_ready) begin
            start_next   = cfg_data;
            st_next.line = cfg_clamp;
        end
    end

    // Queue pointers: push up to two words, pop one
    always_comb begin
        push_n     = s_fire ? step_res.count : 2'd0;
        tail_next  = tail_reg + PTR_W'(push_n);
        head_next  = head_reg + PTR_W'(m_fire);
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode <= MODE_IDLE;
            st_reg.cand <= 4'd0;
            st_reg.wlen <= 6'd0;
            st_reg.acc  <= 32'd0;
            st_reg.line <= 16'd1;
            start_reg   <= 16'd1;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end else begin
            st_reg    <= st_next;
            start_reg <= start_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Queue storage: hold the oldest word at the tail pointer, the second one after it
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[tail_reg] <= step_res.kind0;
        end
        if (push_n == 2'd2) begin
            q_mem[tail_reg + PTR_W'(1)] <= step_res.kind1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue over-filled");

    a_wlen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.wlen <= 6'(MAX_WORD_LENGTH))
        else $error("word length past its limit");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tdata == CH_NUL) |=> (st_reg.mode == MODE_IDLE))
        else $error("scanner not idle after end of input");

    a_end_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tdata == CH_NUL) |=> (st_reg.line == start_clamp))
        else $error("line counter not reloaded after end of input");

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.line <= LINE_LIMIT)
        else $error("line counter past its limit");

endmodule
`default_nettype wire

>>> src/ctlex_step.sv
// Combinational next-state and token logic for one source byte.
`default_nettype none
module ctlex_step #(
    parameter logic [15:0] LINE_LIMIT      = 16'hFFFF,
    parameter int unsigned MAX_WORD_LENGTH = 63
) (
    input  wire logic [7:0]           src_byte,
    input  wire ctlex_pkg::lex_state_t cur,
    input  wire logic [15:0]          line_reload,
    output ctlex_pkg::lex_state_t     nxt,
    output ctlex_pkg::lex_res_t       res
);
    import ctlex_pkg::*;

    logic       is_letter, is_digit, is_space;
    logic [3:0] cand_filt, cand_word;
    logic [5:0] wlen_base, wlen_inc;
    kind_t      word_kind;
    logic       have_end;
    kind_t      end_kind;
    logic       have_own;
    kind_t      own_kind;
    logic [31:0] digit_val;

    assign is_letter = (src_byte >= "a" && src_byte <= "z") ||
                       (src_byte >= "A" && src_byte <= "Z");
    assign is_digit  = (src_byte >= "0" && src_byte <= "9");
    assign is_space  = (src_byte == " ") || (src_byte >= 8'd9 && src_byte <= 8'd13);
    assign digit_val = {24'd0, src_byte - CH_ZERO};

    // Class of the word held so far, first matching keyword wins
    always_comb begin
        word_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cur.cand[k] && cur.wlen == {3'd0, kw_len(2'(k))}) begin
                word_kind = kw_kind(2'(k));
            end
        end
    end

    // Candidate filter for the incoming letter or digit; a new word starts at position zero
    assign cand_word = (cur.mode == MODE_WORD) ? cur.cand : 4'hF;
    assign wlen_base = (cur.mode == MODE_WORD) ? cur.wlen : 6'd0;
    assign wlen_inc  = (wlen_base < 6'(MAX_WORD_LENGTH)) ? wlen_base + 6'd1 : wlen_base;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            cand_filt[k] = cand_word[k] && (wlen_base < {3'd0, kw_len(2'(k))}) &&
                           (kw_char(2'(k), wlen_base[2:0]) == src_byte);
        end
    end

    always_comb begin
        nxt      = cur;
        have_end = 1'b0;
        end_kind = KIND_END;
        have_own = 1'b0;
        own_kind = KIND_END;

        if (cur.mode == MODE_WORD && (is_letter || is_digit)) begin
            nxt.cand = cand_filt;
            nxt.wlen = wlen_inc;
            have_own = 1'b1;
            own_kind = KIND_ECHO;
        end else if (cur.mode == MODE_NUM && is_digit) begin
            nxt.acc = (cur.acc << 3) + (cur.acc << 1) + digit_val;
        end else begin
            // Close any pending token, then handle the byte from idle
            case (cur.mode)
                MODE_WORD: begin
                    have_end = 1'b1;
                    end_kind = word_kind;
                end
                MODE_NUM: begin
                    have_end = 1'b1;
                    end_kind = KIND_NUMBER;
                end
                default: ;
            endcase
            nxt.mode = MODE_IDLE;

            if (src_byte == CH_NUL) begin
                have_own = 1'b1;
                own_kind = KIND_END;
                nxt.line = line_reload;
            end else if (is_space) begin
                if (src_byte == CH_NEWLINE && cur.line < LINE_LIMIT) begin
                    nxt.line = cur.line + 16'd1;
                end
            end else if (is_letter) begin
                nxt.mode = MODE_WORD;
                nxt.cand = cand_filt;
                nxt.wlen = wlen_inc;
                have_own = 1'b1;
                own_kind = KIND_ECHO;
            end else if (is_digit) begin
                nxt.mode = MODE_NUM;
                nxt.acc  = digit_val;
            end else begin
                have_own = 1'b1;
                case (src_byte)
                    "(":     own_kind = KIND_LPAR;
                    ")":     own_kind = KIND_RPAR;
                    "{":     own_kind = KIND_LBRACE;
                    "}":     own_kind = KIND_RBRACE;
                    ";":     own_kind = KIND_SEMI;
                    default: own_kind = KIND_UNKNOWN;
                endcase
            end
        end
    end

    always_comb begin
        res.count = {1'b0, have_end} + {1'b0, have_own};
        res.kind0 = have_end ? end_kind : own_kind;
        res.kind1 = own_kind;
    end

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking stream testbench for the C subset token lexer core.
`timescale 1ns / 1ps

module tb_top;
    import ctlex_pkg::*;

    localparam logic [15:0] LINE_MAX    = 16'hFFFF;
    localparam int          WORD_MAX    = 63;
    localparam int          SETTLE      = 8;    // cycles to let the output queue go quiet
    localparam int          STALL_PCT   = 34;
    localparam int          PHASE_BYTES = 300;

    // Directed row: the byte, and where it is obvious, the token words it must raise
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic [1:0] count;
        kind_t      k0;
        kind_t      k1;
    } lex_row_t;

    logic        aclk;
    logic        aresetn;
    logic [7:0]  s_tdata;      // source_byte [7:0]
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  m_tdata;      // token_kind [3:0], zero above
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] cfg_data;
    logic        cfg_valid;
    logic        cfg_ready;

    c_subset_token_lexer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // Keyword spellings and the kinds they class as
    string kw_word  [4] = '{"int", "char", "void", "return"};
    kind_t kw_kinds [4] = '{KIND_INT, KIND_CHAR, KIND_VOID, KIND_RETURN};
    string punct_chars = "(){};";
    string space_chars = " \t\n\013\014\015";

    // Scanner state as the predictor sees it
    logic [15:0] start_line;
    mode_t       scan_mode;
    logic [31:0] num_acc;
    logic [3:0]  kw_cand;
    logic [5:0]  word_len;
    logic [15:0] line_now;
    logic [15:0] token_line;

    // Token words raised by the byte just lexed
    int          step_n;
    kind_t       step_k [2];

    kind_t       pending_kinds [$];
    kind_t       want;

    // Typed expectation for the directed byte currently on offer
    logic        typed_valid;
    logic [1:0]  typed_count;
    kind_t       typed_k0;
    kind_t       typed_k1;

    logic        stall_on;
    int          err_count;
    int          bytes_sent;
    int          bytes_lexed;
    int          words_checked;
    int          settings_used;
    logic [15:0] start_vals [5];

    lex_row_t dir_rows [24] = '{
        '{8'h00, 1'b1, 2'd1, KIND_END,     KIND_END},     // end straight after reset
        '{"(",   1'b1, 2'd1, KIND_LPAR,    KIND_END},
        '{")",   1'b1, 2'd1, KIND_RPAR,    KIND_END},
        '{"{",   1'b1, 2'd1, KIND_LBRACE,  KIND_END},
        '{"}",   1'b1, 2'd1, KIND_RBRACE,  KIND_END},
        '{8'hFF, 1'b1, 2'd1, KIND_UNKNOWN, KIND_END},     // top of the byte range
        '{8'h80, 1'b1, 2'd1, KIND_UNKNOWN, KIND_END},     // first byte above ASCII
        '{"i",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"n",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"t",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{8'h0A, 1'b0, 2'd0, KIND_END,     KIND_END},     // newline closes the keyword
        '{"9",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"0",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{";",   1'b1, 2'd2, KIND_NUMBER,  KIND_SEMI},    // number closed, then its own token
        '{"r",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"e",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"t",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"u",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"r",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"n",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{8'h09, 1'b0, 2'd0, KIND_END,     KIND_END},     // tab closes return
        '{"x",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{"1",   1'b0, 2'd0, KIND_END,     KIND_END},
        '{8'h00, 1'b1, 2'd2, KIND_IDENT,   KIND_END}      // pending word flushed before end
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void add_kind(input kind_t k);
        step_k[step_n] = k;
        step_n++;
    endfunction

    // Drop every keyword that no longer matches, and grow the word (saturating)
    function automatic void take_word_char(input logic [7:0] c);
        for (int k = 0; k < 4; k++) begin
            if (kw_cand[k] && !(word_len < kw_word[k].len() && kw_word[k][word_len] == c))
                kw_cand[k] = 1'b0;
        end
        if (word_len < WORD_MAX)
            word_len++;
    endfunction

    function automatic kind_t word_class();
        for (int k = 0; k < 4; k++) begin
            if (kw_cand[k] && word_len == kw_word[k].len())
                return kw_kinds[k];
        end
        return KIND_IDENT;
    endfunction

    function automatic void lex_reset();
        start_line = 16'd1;
        scan_mode  = MODE_IDLE;
        num_acc    = '0;
        kw_cand    = '0;
        word_len   = '0;
        line_now   = start_line;
        token_line = start_line;
    endfunction

    function automatic void load_start_line(input logic [15:0] v);
        start_line = v;
        line_now   = (v > LINE_MAX) ? LINE_MAX : v;
        token_line = line_now;
    endfunction

    // Lex one byte: first the token the byte closes, then whatever it opens
    function automatic void lex_step(input logic [7:0] c);
        step_n = 0;
        if (scan_mode == MODE_WORD) begin
            if (is_alpha(c) || is_digit(c)) begin
                take_word_char(c);
                add_kind(KIND_ECHO);
                return;
            end
            add_kind(word_class());
            scan_mode = MODE_IDLE;
        end else if (scan_mode == MODE_NUM) begin
            if (is_digit(c)) begin
                num_acc = num_acc * 32'd10 + 32'(c - CH_ZERO);
                return;
            end
            add_kind(KIND_NUMBER);
            scan_mode = MODE_IDLE;
        end else if (scan_mode != MODE_IDLE) begin
            scan_mode = MODE_IDLE;
        end

        if (c == CH_NUL) begin
            token_line = line_now;
            add_kind(KIND_END);
            line_now = (start_line > LINE_MAX) ? LINE_MAX : start_line;
            return;
        end
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            if (c == CH_NEWLINE && line_now < LINE_MAX)
                line_now++;
            return;
        end
        token_line = line_now;
        if (is_alpha(c)) begin
            scan_mode = MODE_WORD;
            kw_cand   = 4'hF;
            word_len  = '0;
            take_word_char(c);
            add_kind(KIND_ECHO);
        end else if (is_digit(c)) begin
            scan_mode = MODE_NUM;
            num_acc   = 32'(c - CH_ZERO);
        end else if (c == "(") begin
            add_kind(KIND_LPAR);
        end else if (c == ")") begin
            add_kind(KIND_RPAR);
        end else if (c == "{") begin
            add_kind(KIND_LBRACE);
        end else if (c == "}") begin
            add_kind(KIND_RBRACE);
        end else if (c == ";") begin
            add_kind(KIND_SEMI);
        end else begin
            add_kind(KIND_UNKNOWN);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, sink pacing and the checker
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hold m_tready low at random while stalling is enabled
    always @(negedge aclk) begin
        m_tready <= !stall_on || ($urandom_range(99) >= STALL_PCT);
    end

    // Sample both channels at the rising edge; check output before lexing the new word
    always @(posedge aclk) begin
        if (!aresetn) begin
            lex_reset();
            pending_kinds.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_kinds.size() == 0) begin
                    $error("token word %0d arrived with no token pending", m_tdata);
                    err_count++;
                end else begin
                    want = pending_kinds.pop_front();
                    if (m_tdata[3:0] !== 4'(want)) begin
                        $error("token_kind: expected %0d (%s), got %0d",
                               want, want.name(), m_tdata[3:0]);
                        err_count++;
                    end
                    if (m_tdata[7:4] !== 4'd0) begin
                        $error("tdata padding: expected 0, got %0d", m_tdata[7:4]);
                        err_count++;
                    end
                    words_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                load_start_line(cfg_data);
            if (s_tvalid && s_tready) begin
                lex_step(s_tdata);
                bytes_lexed++;
                // A typed row overrides the predictor's words; its state still advances
                if (typed_valid) begin
                    if (typed_count >= 2'd1) pending_kinds.push_back(typed_k0);
                    if (typed_count == 2'd2) pending_kinds.push_back(typed_k1);
                end else begin
                    for (int i = 0; i < step_n; i++)
                        pending_kinds.push_back(step_k[i]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offer one byte and return at the falling edge after it is taken.
    // tvalid stays high into the next word unless idle cycles are drawn,
    // one at a time, each with the stall probability.
    task automatic put_byte(input logic [7:0] b);
        while (stall_on && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic drop_source();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait for every pending token word, then let the queue settle
    task automatic wait_drained();
        while (pending_kinds.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_start_line(input logic [15:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(2) == 0) ? CH_ZERO + 8'($urandom_range(9)) : rand_letter();
    endfunction

    // Mostly well-formed tokens with random content; some near-miss keywords and noise
    task automatic put_random_token();
        logic [7:0] seq [$];
        int         pick;
        int         len;
        string      w;
        pick = $urandom_range(99);
        if (pick < 25) begin
            w = kw_word[$urandom_range(3)];
            for (int i = 0; i < w.len(); i++) seq.push_back(w[i]);
            // near miss: chop the last letter or run on past the keyword
            if (pick >= 18) begin
                if (pick[0]) void'(seq.pop_back());
                else seq.push_back(rand_alnum());
            end
        end else if (pick < 40) begin
            // now and then a word long enough to saturate the length count
            len = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            seq.push_back(rand_letter());
            repeat (len - 1) seq.push_back(rand_alnum());
        end else if (pick < 52) begin
            // up to 14 digits, enough to wrap the accumulator
            repeat ($urandom_range(1, 14)) seq.push_back(CH_ZERO + 8'($urandom_range(9)));
        end else if (pick < 70) begin
            seq.push_back(punct_chars[$urandom_range(4)]);
        end else if (pick < 86) begin
            repeat ($urandom_range(1, 3)) seq.push_back(space_chars[$urandom_range(5)]);
        end else if (pick < 89) begin
            seq.push_back(CH_NUL);
        end else begin
            seq.push_back(8'($urandom_range(255)));
        end
        foreach (seq[i]) put_byte(seq[i]);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        stall_on      = 1'b1;
        typed_valid   = 1'b0;
        typed_count   = '0;
        typed_k0      = KIND_END;
        typed_k1      = KIND_END;
        err_count     = 0;
        bytes_sent    = 0;
        bytes_lexed   = 0;
        words_checked = 0;
        settings_used = 1;
        start_vals    = '{16'd0, 16'($urandom), LINE_MAX, 16'($urandom), 16'd1};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table under the reset value of start_line
        foreach (dir_rows[r]) begin
            typed_valid = dir_rows[r].typed;
            typed_count = dir_rows[r].count;
            typed_k0    = dir_rows[r].k0;
            typed_k1    = dir_rows[r].k1;
            put_byte(dir_rows[r].ch);
        end
        typed_valid = 1'b0;
        drop_source();

        // Random phases, each under a fresh start_line; the middle one runs without stalls
        foreach (start_vals[p]) begin
            wait_drained();
            write_start_line(start_vals[p]);
            stall_on = (p != 2);
            while (bytes_sent < (p + 1) * PHASE_BYTES) put_random_token();
            put_byte(CH_NUL);
            drop_source();
        end
        stall_on = 1'b1;

        wait_drained();
        $display("Lexed %0d source bytes under %0d start_line settings,",
                 bytes_lexed, settings_used);
        $display("  %0d token words matched against the predictor.", words_checked);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5ms;
        $error("run timed out with %0d token words pending", pending_kinds.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
src/ctlex_pkg.sv
src/ctlex_step.sv
src/c_subset_token_lexer_core.sv
verif/tb_top.sv
